@@ hw/rtl/sgm_pkg.sv @@
// Shared constants, register codes and item types of the Sobel gradient block.
`default_nettype none
package sgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;
  localparam int PIXEL_BITS = 8;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LAG_W      = WCFG_W;

  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int MAG_MAX    = 1442;
  localparam int SQ_W       = 22;
  localparam int SQ_STEPS   = 11;

  localparam int RAM_W      = 2 * PIXEL_BITS;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd512;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  is_pixel;
    logic [PIXEL_BITS-1:0] pixel;
    logic [PIXEL_BITS-1:0] top;
    logic [PIXEL_BITS-1:0] mid;
    logic                  emit;
    logic                  border;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic                  last;
  } job_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/sgm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/sgm_front.sv @@
// Front part: registers, position counters, item classification and line buffer access.
`default_nettype none
module sgm_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic                             in_cmd,
  input  wire logic [sgm_pkg::PIXEL_BITS-1:0]   in_pixel,
  input  wire logic [sgm_pkg::QCNT_W-1:0]       q_count,
  output logic                                  q_push,
  output sgm_pkg::job_t                         q_job,
  output logic                                  ram_we,
  output logic      [sgm_pkg::COL_W-1:0]        ram_waddr,
  output logic      [sgm_pkg::RAM_W-1:0]        ram_wdata,
  output logic      [sgm_pkg::COL_W-1:0]        ram_raddr,
  input  wire logic [sgm_pkg::RAM_W-1:0]        ram_rdata
);
  import sgm_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic [COL_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [WCFG_W-1:0]  width_r;
  logic [HCFG_W-1:0]  height_r;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [COL_W-1:0]   emit_col_r, emit_col_nxt;
  logic [ROW_W-1:0]   emit_row_r, emit_row_nxt;
  logic [LAG_W-1:0]   lag_r, lag_nxt;
  logic               s1_vld_r;
  job_t               s1_job_r, s1_job_nxt;
  logic [COL_W-1:0]   s1_addr_r;

  logic [WCFG_W-1:0]  w_eff, w_plus1, col_inc, ecol_inc, ecol_ext, tail_span;
  logic [HCFG_W-1:0]  h_eff, row_inc, erow_inc, erow_inc2;
  logic               accept, is_pixel, pix_emit, flush_ok, flush_emit, emit;
  logic               ecol_end, erow_end;

  always_comb begin
    if (width_r < WCFG_W'(MIN_SIZE)) begin
      w_eff = WCFG_W'(MIN_SIZE);
    end else if (width_r > WCFG_W'(MAX_WIDTH)) begin
      w_eff = WCFG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < HCFG_W'(MIN_SIZE)) begin
      h_eff = HCFG_W'(MIN_SIZE);
    end else if (height_r > HCFG_W'(MAX_HEIGHT)) begin
      h_eff = HCFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_full   = (state_r != ST_RUN) ||
                     ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_vld_r) >= (QCNT_W+1)'(QDEPTH));
  assign accept    = in_push && !in_full;
  assign is_pixel  = (in_cmd == CMD_PIXEL);

  assign w_plus1   = w_eff + WCFG_W'(1);
  assign col_inc   = WCFG_W'(in_col_r) + WCFG_W'(1);
  assign row_inc   = HCFG_W'(in_row_r) + HCFG_W'(1);
  assign ecol_ext  = WCFG_W'(emit_col_r);
  assign ecol_inc  = ecol_ext + WCFG_W'(1);
  assign erow_inc  = HCFG_W'(emit_row_r) + HCFG_W'(1);
  assign erow_inc2 = HCFG_W'(emit_row_r) + HCFG_W'(2);
  assign ecol_end  = (ecol_inc >= w_eff);
  assign erow_end  = (erow_inc >= h_eff);
  assign pix_emit  = (lag_r >= w_plus1);

  // A flush item only drains results of the frame's tail once all of its pixels are in.
  always_comb begin
    flush_ok  = 1'b1;
    tail_span = w_plus1;
    if (erow_end) begin
      tail_span = (ecol_ext < w_eff) ? (w_eff - ecol_ext) : WCFG_W'(1);
    end else if (!((erow_inc2 == h_eff) && ecol_end)) begin
      flush_ok = 1'b0;
    end
  end

  assign flush_emit = (lag_r != '0) && flush_ok && (lag_r >= tail_span);
  assign emit       = is_pixel ? pix_emit : flush_emit;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    emit_col_nxt = emit_col_r;
    emit_row_nxt = emit_row_r;
    lag_nxt      = lag_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          if (is_pixel) begin
            if (col_inc >= w_eff) begin
              in_col_nxt = '0;
              in_row_nxt = (row_inc >= h_eff) ? '0 : in_row_r + ROW_W'(1);
            end else begin
              in_col_nxt = in_col_r + COL_W'(1);
            end
            lag_nxt = pix_emit ? w_plus1 : lag_r + LAG_W'(1);
          end else if (flush_emit) begin
            lag_nxt = lag_r - LAG_W'(1);
          end
          if (emit) begin
            if (ecol_end) begin
              emit_col_nxt = '0;
              emit_row_nxt = erow_end ? '0 : emit_row_r + ROW_W'(1);
            end else begin
              emit_col_nxt = emit_col_r + COL_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    s1_job_nxt          = '0;
    s1_job_nxt.is_pixel = is_pixel;
    s1_job_nxt.pixel    = in_pixel;
    s1_job_nxt.emit     = emit;
    s1_job_nxt.border   = (emit_row_r == '0) || erow_end || (emit_col_r == '0) || ecol_end;
    s1_job_nxt.row      = emit_row_r;
    s1_job_nxt.col      = emit_col_r;
    s1_job_nxt.last     = ecol_end && erow_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
      in_col_r   <= '0;
      in_row_r   <= '0;
      emit_col_r <= '0;
      emit_row_r <= '0;
      lag_r      <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      emit_col_r <= emit_col_nxt;
      emit_row_r <= emit_row_nxt;
      lag_r      <= lag_nxt;
      s1_vld_r   <= accept && (is_pixel || emit);
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data[WCFG_W-1:0];
          REG_IMAGE_HEIGHT: height_r <= cfg_data[HCFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_job_r  <= s1_job_nxt;
      s1_addr_r <= in_col_r;
    end
  end

  // The line buffer entry holds the two rows above the current column.
  assign ram_raddr = in_col_r;

  always_comb begin
    q_push     = s1_vld_r;
    q_job      = s1_job_r;
    q_job.top  = ram_rdata[RAM_W-1:PIXEL_BITS];
    q_job.mid  = ram_rdata[PIXEL_BITS-1:0];
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_vld_r && s1_job_r.is_pixel;
      ram_waddr = s1_addr_r;
      ram_wdata = {ram_rdata[PIXEL_BITS-1:0], s1_job_r.pixel};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sgm_queue.sv @@
// Short queue of classified items between the front and the back part.
`default_nettype none
module sgm_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire sgm_pkg::job_t            job_in,
  input  wire logic                     pop,
  output sgm_pkg::job_t                 job_out,
  output logic                          empty,
  output logic [sgm_pkg::QCNT_W-1:0]    count
);
  import sgm_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign job_out = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sgm_back.sv @@
// Back part: 3x3 window, Sobel gradients, squared sum, pipelined square root and result buffer.
`default_nettype none
module sgm_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_empty,
  input  wire sgm_pkg::job_t                     q_job,
  output logic                                   q_pop,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic signed [sgm_pkg::GRAD_W-1:0]      out_grad_x,
  output logic signed [sgm_pkg::GRAD_W-1:0]      out_grad_y,
  output logic        [sgm_pkg::MAG_W-1:0]       out_magnitude,
  output logic        [sgm_pkg::ROW_W-1:0]       out_row,
  output logic        [sgm_pkg::COL_W-1:0]       out_col,
  output logic                                   out_frame_last
);
  import sgm_pkg::*;

  typedef struct packed {
    res_t             r;
    logic [MAG_W-1:0] mag;
  } outq_t;

  logic [PIXEL_BITS-1:0] win_r [9];
  logic [PIXEL_BITS-1:0] win_nxt [9];
  logic [GRAD_W-1:0]     left_s, right_s, top_s, bot_s;
  logic                  adv;

  logic                  g_vld_r;
  res_t                  g_res_r;
  logic                  m_vld_r;
  res_t                  m_res_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic signed [2*GRAD_W-1:0] prod_x, prod_y;

  logic                  vld_r [SQ_STEPS+1];
  res_t                  pl_r  [SQ_STEPS+1];
  logic [SQ_W-1:0]       rem_r [SQ_STEPS+1];
  logic [SQ_W-1:0]       root_r [SQ_STEPS+1];

  outq_t                 oq_r [2];
  logic                  oq_wp_r, oq_rp_r;
  logic [1:0]            oq_cnt_r;
  logic                  oq_full, oq_push, oq_pop;

  assign oq_full = (oq_cnt_r == 2'd2);
  assign adv     = !(vld_r[SQ_STEPS] && oq_full);
  assign q_pop   = !q_empty && adv;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (q_pop && q_job.is_pixel) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r*3]   = win_r[r*3+1];
        win_nxt[r*3+1] = win_r[r*3+2];
      end
      win_nxt[2] = q_job.top;
      win_nxt[5] = q_job.mid;
      win_nxt[8] = q_job.pixel;
    end
  end

  assign left_s  = GRAD_W'(win_nxt[0]) + (GRAD_W'(win_nxt[3]) << 1) + GRAD_W'(win_nxt[6]);
  assign right_s = GRAD_W'(win_nxt[2]) + (GRAD_W'(win_nxt[5]) << 1) + GRAD_W'(win_nxt[8]);
  assign top_s   = GRAD_W'(win_nxt[0]) + (GRAD_W'(win_nxt[1]) << 1) + GRAD_W'(win_nxt[2]);
  assign bot_s   = GRAD_W'(win_nxt[6]) + (GRAD_W'(win_nxt[7]) << 1) + GRAD_W'(win_nxt[8]);

  assign prod_x = $signed(g_res_r.gx) * $signed(g_res_r.gx);
  assign prod_y = $signed(g_res_r.gy) * $signed(g_res_r.gy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r  <= 1'b0;
      m_vld_r  <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      g_vld_r  <= q_pop && q_job.emit;
      m_vld_r  <= g_vld_r;
      vld_r[0] <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_res_r.row  <= q_job.row;
      g_res_r.col  <= q_job.col;
      g_res_r.last <= q_job.last;
      g_res_r.gx   <= q_job.border ? '0 : $signed(left_s - right_s);
      g_res_r.gy   <= q_job.border ? '0 : $signed(top_s - bot_s);
      m_res_r      <= g_res_r;
      sqx_r        <= SQ_W'($unsigned(prod_x));
      sqy_r        <= SQ_W'($unsigned(prod_y));
      pl_r[0]      <= m_res_r;
      rem_r[0]     <= sqx_r + sqy_r;
      root_r[0]    <= '0;
    end
  end

  // One bit pair of the square root per stage, from the top pair down.
  for (genvar s = 1; s <= SQ_STEPS; s++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - s));
    logic [SQ_W-1:0] trial;
    assign trial = root_r[s-1] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[s] <= pl_r[s-1];
        if (rem_r[s-1] >= trial) begin
          rem_r[s]  <= rem_r[s-1] - trial;
          root_r[s] <= (root_r[s-1] >> 1) + BIT;
        end else begin
          rem_r[s]  <= rem_r[s-1];
          root_r[s] <= root_r[s-1] >> 1;
        end
      end
    end
  end

  assign oq_push   = adv && vld_r[SQ_STEPS];
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= !oq_wp_r;
      end
      if (oq_pop) begin
        oq_rp_r <= !oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r].r   <= pl_r[SQ_STEPS];
      oq_r[oq_wp_r].mag <= root_r[SQ_STEPS][MAG_W-1:0];
    end
  end

  assign out_grad_x     = oq_r[oq_rp_r].r.gx;
  assign out_grad_y     = oq_r[oq_rp_r].r.gy;
  assign out_magnitude  = oq_r[oq_rp_r].mag;
  assign out_row        = oq_r[oq_rp_r].r.row;
  assign out_col        = oq_r[oq_rp_r].r.col;
  assign out_frame_last = oq_r[oq_rp_r].r.last;

endmodule
`default_nettype wire

@@ hw/rtl/sobel_gradient_magnitude_top.sv @@
// Top level of the streaming 3x3 Sobel gradient and magnitude block.
//
//   channel   direction  handshake            payload
//   in_       input      in_push / in_full    in_cmd, in_pixel
//   out_      output     out_pop / out_empty  grad_x, grad_y, magnitude, row, col, frame_last
//   cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is accepted per cycle while the result side drains; each result passes the
// item queue, the gradient, square and sum registers and the eleven-stage square root.
// After reset the line buffer RAM is cleared one entry a cycle, all 1024 entries, with in_full high.
// A stalled result side fills the two-entry result buffer, then halts the back pipeline and
// fills the four-entry item queue, and only then raises in_full.
`default_nettype none
module sobel_gradient_magnitude_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic                              in_cmd,
  input  wire logic [sgm_pkg::PIXEL_BITS-1:0]    in_pixel,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic signed [sgm_pkg::GRAD_W-1:0]      out_grad_x,
  output logic signed [sgm_pkg::GRAD_W-1:0]      out_grad_y,
  output logic        [sgm_pkg::MAG_W-1:0]       out_magnitude,
  output logic        [sgm_pkg::ROW_W-1:0]       out_row,
  output logic        [sgm_pkg::COL_W-1:0]       out_col,
  output logic                                   out_frame_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sgm_pkg::*;

  logic              q_push, q_pop, q_empty;
  job_t              q_job_in, q_job_out;
  logic [QCNT_W-1:0] q_count;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;

  sgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_cmd    (in_cmd),
    .in_pixel  (in_pixel),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_job     (q_job_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sgm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sgm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_job_in),
    .pop     (q_pop),
    .job_out (q_job_out),
    .empty   (q_empty),
    .count   (q_count)
  );

  sgm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_job          (q_job_out),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_magnitude  (out_magnitude),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

  a_reset_blocks_input: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input side open in the cycle after reset");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count != QCNT_W'(QDEPTH)))
    else $error("item queue written while full");

  a_flush_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_job_in.is_pixel) |-> (q_job_in.emit && q_job_in.border))
    else $error("flush item queued without a border result");

  a_magnitude_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_magnitude <= MAG_W'(MAG_MAX)))
    else $error("magnitude out of range");

endmodule
`default_nettype wire
